// ----- src/ssat_pkg.sv -----
// shared types, codes and defaults of the switching activity tracker
package ssat_pkg;

  localparam int unsigned SIGNAL_COUNT_DEF = 1024;
  localparam int unsigned TIME_BITS_DEF    = 48;
  localparam int unsigned COUNT_BITS_DEF   = 32;
  localparam int unsigned INDEX_BITS       = 10;
  localparam int unsigned CHAR_BITS        = 8;

  localparam logic MODE_CHANGE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef logic [1:0] code_t;

  localparam code_t CODE_ZERO = 2'd0;
  localparam code_t CODE_ONE  = 2'd1;
  localparam code_t CODE_X    = 2'd2;
  localparam code_t CODE_Z    = 2'd3;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_ONE     = 8'h31;
  localparam logic [CHAR_BITS-1:0] CHAR_Z_LOWER = 8'h7a;
  localparam logic [CHAR_BITS-1:0] CHAR_Z_UPPER = 8'h5a;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC
  } state_t;

  function automatic code_t char_code(input logic [CHAR_BITS-1:0] c);
    code_t res;
    priority if (c == CHAR_ZERO) begin
      res = CODE_ZERO;
    end else if (c == CHAR_ONE) begin
      res = CODE_ONE;
    end else if (c == CHAR_Z_LOWER || c == CHAR_Z_UPPER) begin
      res = CODE_Z;
    end else begin
      res = CODE_X;
    end
    return res;
  endfunction

  function automatic logic is_unknown(input code_t c);
    return (c == CODE_X) || (c == CODE_Z);
  endfunction

endpackage

// ----- src/signal_switching_activity_tracker_unit.sv -----
// top level of the switching activity tracker
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------------
//  request  | in_mode in_signal_index in_stamp in_value_char | start high, busy low
//  result   | out_seen out_high_time out_toggle_halves       | out_valid, one cycle
//           | out_final_code                                 |
//
// an item has three steps: table read, time difference, saturating sums and write back
// a query result is registered from the sums step and shown on out_valid
// after reset busy stays high while every table entry is swept clear
// the receiver cannot stall; each result is shown exactly once
module signal_switching_activity_tracker_unit #(
  parameter int unsigned SIGNAL_COUNT = ssat_pkg::SIGNAL_COUNT_DEF,
  parameter int unsigned TIME_BITS    = ssat_pkg::TIME_BITS_DEF,
  parameter int unsigned COUNT_BITS   = ssat_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_mode,
  input  logic [ssat_pkg::INDEX_BITS-1:0]  in_signal_index,
  input  logic [TIME_BITS-1:0]             in_stamp,
  input  logic [ssat_pkg::CHAR_BITS-1:0]   in_value_char,
  output logic                             out_valid,
  output logic                             out_seen,
  output logic [TIME_BITS-1:0]             out_high_time,
  output logic [COUNT_BITS-1:0]            out_toggle_halves,
  output ssat_pkg::code_t                  out_final_code
);

  import ssat_pkg::*;

  localparam int unsigned AW = (SIGNAL_COUNT > 1) ? $clog2(SIGNAL_COUNT) : 1;
  localparam int unsigned XW = (AW > INDEX_BITS) ? AW : INDEX_BITS;
  localparam int unsigned WW = 1 + 2 + TIME_BITS + TIME_BITS + COUNT_BITS;

  typedef struct packed {
    logic                  seen;
    code_t                 code;
    logic [TIME_BITS-1:0]  stamp;
    logic [TIME_BITS-1:0]  high;
    logic [COUNT_BITS-1:0] toggle;
  } entry_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;

  logic                 mode_r;
  logic                 valid_r;
  logic [AW-1:0]        addr_r;
  logic [TIME_BITS-1:0] stamp_r;
  code_t                code_r;

  logic [TIME_BITS-1:0] diff_r;
  logic                 add_high_r;
  logic [1:0]           inc_r;
  logic                 seen_r;

  logic                  out_valid_r;
  logic                  out_seen_r;
  logic [TIME_BITS-1:0]  out_high_r;
  logic [COUNT_BITS-1:0] out_toggle_r;
  code_t                 out_code_r;

  logic            accept;
  logic            mem_we;
  logic            wr_clear;
  logic            out_load;
  logic [XW-1:0]   idx_ext;
  logic [AW-1:0]   in_addr;
  logic            in_valid;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_entry;
  logic [WW-1:0]   rd_data;
  entry_t          rd_entry;

  logic [TIME_BITS:0]    diff_full;
  logic                  stamp_gt;
  logic                  seen_q;
  logic [TIME_BITS:0]    high_sum;
  logic [COUNT_BITS:0]   toggle_sum;
  logic [TIME_BITS-1:0]  high_new;
  logic [COUNT_BITS-1:0] toggle_new;

  assign accept   = start && !busy;
  assign idx_ext  = XW'(in_signal_index);
  assign in_addr  = idx_ext[AW-1:0];
  assign in_valid = 32'(in_signal_index) < SIGNAL_COUNT;
  assign rd_entry = entry_t'(rd_data);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    mem_we    = 1'b0;
    wr_clear  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        wr_clear = 1'b1;
        if (clr_cnt_r == AW'(SIGNAL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        mem_we    = (mode_r == MODE_CHANGE) && valid_r;
        out_load  = (mode_r == MODE_QUERY);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      valid_r <= in_valid;
      addr_r  <= in_addr;
      stamp_r <= in_stamp;
      code_r  <= char_code(in_value_char);
    end
  end

  // time difference and increments against the stored entry
  assign diff_full = {1'b0, stamp_r} - {1'b0, rd_entry.stamp};
  assign stamp_gt  = !diff_full[TIME_BITS] && (diff_full[TIME_BITS-1:0] != '0);
  assign seen_q    = valid_r && rd_entry.seen;

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      diff_r     <= diff_full[TIME_BITS-1:0];
      add_high_r <= seen_q && stamp_gt && (rd_entry.code == CODE_ONE);
      seen_r     <= seen_q;
      // a query never counts a transition
      if ((mode_r == MODE_CHANGE) && seen_q && stamp_gt && (code_r != rd_entry.code)) begin
        inc_r <= (is_unknown(code_r) || is_unknown(rd_entry.code)) ? 2'd1 : 2'd2;
      end else begin
        inc_r <= 2'd0;
      end
    end
  end

  // saturating sums; an unseen entry starts from zero
  assign high_sum   = {1'b0, rd_entry.high} + {1'b0, (add_high_r ? diff_r : '0)};
  assign toggle_sum = {1'b0, rd_entry.toggle} + (COUNT_BITS + 1)'(inc_r);

  always_comb begin
    if (!seen_r) begin
      high_new   = '0;
      toggle_new = '0;
    end else begin
      high_new   = high_sum[TIME_BITS] ? '1 : high_sum[TIME_BITS-1:0];
      toggle_new = toggle_sum[COUNT_BITS] ? '1 : toggle_sum[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    if (wr_clear) begin
      wr_addr  = clr_cnt_r;
      wr_entry = '0;
    end else begin
      wr_addr         = addr_r;
      wr_entry.seen   = 1'b1;
      wr_entry.code   = code_r;
      wr_entry.stamp  = stamp_r;
      wr_entry.high   = high_new;
      wr_entry.toggle = toggle_new;
    end
  end

  ssat_table #(
    .DEPTH (SIGNAL_COUNT),
    .WIDTH (WW)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data (WW'(wr_entry)),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_seen_r   <= seen_r;
      out_high_r   <= high_new;
      out_toggle_r <= toggle_new;
      out_code_r   <= seen_r ? rd_entry.code : CODE_ZERO;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_seen          = out_seen_r;
  assign out_high_time     = out_high_r;
  assign out_toggle_halves = out_toggle_r;
  assign out_final_code    = out_code_r;

  a_accept_reads : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_READ)
    else $error("accepted request did not start a table read");

  a_calc_after_read : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CALC |-> $past(state_r == ST_READ))
    else $error("sum stage entered without a table read");

  a_result_from_query : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_CALC) && $past(mode_r == MODE_QUERY) && !$past(mem_we))
    else $error("result strobe not caused by a query");

endmodule

// ----- src/ssat_table.sv -----
// per-signal table: one write port, one registered read port
module ssat_table #(
  parameter int unsigned DEPTH = ssat_pkg::SIGNAL_COUNT_DEF,
  parameter int unsigned WIDTH = 131
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
